### rtl/cv3_pkg.sv
// Shared types and constants for the 3x3 convolution filter.
// No dependencies; every other file of the block but cv3_ram refers to it by scoped name.
package cv3_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int COL_W          = 10;   // log2 of MAX_WIDTH
   localparam int ROW_W          = 12;   // row counter wraps at 4096
   localparam int LINE_W         = 11;   // line_width register
   localparam int PIX_W          = 24;   // blue, green, red bytes
   localparam int COEF_W         = 16;   // signed Q8.8
   localparam int COEF_FRAC_BITS = 8;
   localparam int TAPS           = 9;
   localparam int PROD_W         = COEF_W + 9;  // coefficient times zero-extended byte
   localparam int ACC_W          = PROD_W + 4;  // room for nine products
   localparam logic [47:0] COEF_ROW_RESET = 48'h001C_001C_001C;
   localparam logic [LINE_W-1:0] LINE_RESET = LINE_W'(MAX_WIDTH);

   typedef enum logic [2:0] {
      CSR_LINE_WIDTH  = 3'd0,
      CSR_COLOR_MODE  = 3'd1,
      CSR_COEF_TOP    = 3'd2,
      CSR_COEF_MID    = 3'd3,
      CSR_COEF_BOTTOM = 3'd4
   } csr_index_type;

   // window tap r*3+c: r = 0 top row, c = 0 left column
   typedef logic [TAPS-1:0][PIX_W-1:0]  window_type;
   typedef logic [TAPS-1:0][COEF_W-1:0] kernel_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } pos_type;

endpackage

### rtl/cv3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the two line stores.
module cv3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read while the reader is stalled
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cv3_line_window.sv
// Pixel intake: row/column counters, two line stores and the 3x3 window.
// Depends on cv3_pkg and cv3_ram.
module cv3_line_window (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_in_red,
   input  logic [7:0]                  req_in_green,
   input  logic [7:0]                  req_in_blue,
   input  logic                        req_frame_start,
   input  logic [cv3_pkg::LINE_W-1:0]  line_width,
   input  logic                        down_ready,
   output logic                        win_valid,
   output cv3_pkg::window_type         window,
   output cv3_pkg::pos_type            win_pos
);

   logic                        s1_en;
   logic                        s2_en;
   logic                        accept;
   logic                        s1_move;
   logic [cv3_pkg::LINE_W-1:0]  width_eff;
   logic [cv3_pkg::COL_W-1:0]   col_sel;
   logic [cv3_pkg::ROW_W-1:0]   row_sel;
   logic                        last_col;
   logic [cv3_pkg::COL_W-1:0]   column_count_ff, column_count_in;
   logic [cv3_pkg::ROW_W-1:0]   row_count_ff, row_count_in;

   logic                        valid1_ff, valid1_in;
   logic                        emit1_ff;
   logic [cv3_pkg::PIX_W-1:0]   pix1_ff;
   logic [cv3_pkg::COL_W-1:0]   col1_ff;
   logic [cv3_pkg::ROW_W-1:0]   row1_ff;
   logic                        byp_ff;
   logic [cv3_pkg::PIX_W-1:0]   byp_upper_ff;
   logic [cv3_pkg::PIX_W-1:0]   byp_lower_ff;
   logic [cv3_pkg::PIX_W-1:0]   upper_rd, lower_rd;
   logic [cv3_pkg::PIX_W-1:0]   upper_eff, lower_eff;

   cv3_pkg::window_type         window_ff, window_in;
   logic                        valid2_ff, valid2_in;
   cv3_pkg::pos_type            pos2_ff;

   // handshake chain, back from the kernel
   assign s2_en     = !valid2_ff || down_ready;
   assign s1_move   = valid1_ff && s2_en;
   assign s1_en     = !valid1_ff || s2_en;
   assign accept    = req_valid && s1_en;
   assign req_stall = !s1_en;

   always_comb begin
      if (line_width < cv3_pkg::LINE_W'(3)) begin
         width_eff = cv3_pkg::LINE_W'(3);
      end else if (line_width > cv3_pkg::LINE_RESET) begin
         width_eff = cv3_pkg::LINE_RESET;
      end else begin
         width_eff = line_width;
      end
   end

   always_comb begin
      col_sel  = req_frame_start ? '0 : column_count_ff;
      row_sel  = req_frame_start ? '0 : row_count_ff;
      last_col = ({1'b0, col_sel} + cv3_pkg::LINE_W'(1)) >= width_eff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (last_col) begin
            column_count_in = '0;
            row_count_in    = row_sel + cv3_pkg::ROW_W'(1);
         end else begin
            column_count_in = col_sel + cv3_pkg::COL_W'(1);
            row_count_in    = row_sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // line stores: read on accept, write back when the item leaves stage one
   assign upper_eff = byp_ff ? byp_upper_ff : upper_rd;
   assign lower_eff = byp_ff ? byp_lower_ff : lower_rd;

   cv3_ram #(
      .WIDTH (cv3_pkg::PIX_W),
      .DEPTH (cv3_pkg::MAX_WIDTH)
   ) u_upper (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (col1_ff),
      .wr_data (lower_eff),
      .rd_en   (accept),
      .rd_addr (col_sel),
      .rd_data (upper_rd)
   );

   cv3_ram #(
      .WIDTH (cv3_pkg::PIX_W),
      .DEPTH (cv3_pkg::MAX_WIDTH)
   ) u_lower (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (col1_ff),
      .wr_data (pix1_ff),
      .rd_en   (accept),
      .rd_addr (col_sel),
      .rd_data (lower_rd)
   );

   always_comb begin
      if (accept) begin
         valid1_in = 1'b1;
      end else if (s1_move) begin
         valid1_in = 1'b0;
      end else begin
         valid1_in = valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff  <= {req_in_blue, req_in_green, req_in_red};
         col1_ff  <= col_sel;
         row1_ff  <= row_sel;
         emit1_ff <= (row_sel >= cv3_pkg::ROW_W'(2)) && (col_sel >= cv3_pkg::COL_W'(2));
         // same column written on this edge: forward what goes into the stores
         byp_ff       <= s1_move && (col_sel == col1_ff);
         byp_upper_ff <= lower_eff;
         byp_lower_ff <= pix1_ff;
      end
   end

   always_comb begin
      window_in = window_ff;
      for (int r = 0; r < 3; r++) begin
         window_in[r*3]     = window_ff[r*3 + 1];
         window_in[r*3 + 1] = window_ff[r*3 + 2];
      end
      window_in[2] = upper_eff;
      window_in[5] = lower_eff;
      window_in[8] = pix1_ff;
   end

   always_comb begin
      valid2_in = valid2_ff;
      if (s2_en) begin
         valid2_in = valid1_ff && emit1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         window_ff   <= window_in;
         pos2_ff.row <= row1_ff - cv3_pkg::ROW_W'(1);
         pos2_ff.col <= col1_ff - cv3_pkg::COL_W'(1);
      end
   end

   assign win_valid = valid2_ff;
   assign window    = window_ff;
   assign win_pos   = pos2_ff;

endmodule

### rtl/cv3_kernel.sv
// Weighted 3x3 sum per channel: a product stage, then sum, clamp and result register.
// Depends on cv3_pkg.
module cv3_kernel (
   input  logic                clock,
   input  logic                reset,
   input  logic                win_valid,
   input  cv3_pkg::window_type window,
   input  cv3_pkg::pos_type    win_pos,
   input  cv3_pkg::kernel_type coefs,
   input  logic                color_mode,
   output logic                ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_red,
   output logic [7:0]          rsp_out_green,
   output logic [7:0]          rsp_out_blue,
   output logic [11:0]         rsp_center_row,
   output logic [9:0]          rsp_center_col
);

   logic                              out_en;
   logic                              s3_en;
   logic                              valid3_ff, valid3_in;
   logic signed [cv3_pkg::PROD_W-1:0] prod_ff [3][cv3_pkg::TAPS];
   logic signed [cv3_pkg::PROD_W-1:0] prod_in [3][cv3_pkg::TAPS];
   cv3_pkg::pos_type                  pos3_ff;
   logic signed [cv3_pkg::ACC_W-1:0]  acc [3];
   logic [7:0]                        clamped [3];
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [7:0]                        red_ff, green_ff, blue_ff;
   cv3_pkg::pos_type                  pos_out_ff;

   function automatic logic [7:0] clamp_byte(input logic signed [cv3_pkg::ACC_W-1:0] sum);
      logic [7:0] res;
      if (sum[cv3_pkg::ACC_W-1]) begin
         res = 8'd0;
      end else if (|sum[cv3_pkg::ACC_W-2:cv3_pkg::COEF_FRAC_BITS+8]) begin
         res = 8'd255;
      end else begin
         res = sum[cv3_pkg::COEF_FRAC_BITS +: 8];
      end
      return res;
   endfunction

   assign out_en = !rsp_valid_ff || !rsp_stall;
   assign s3_en  = !valid3_ff || out_en;
   assign ready  = s3_en;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int t = 0; t < cv3_pkg::TAPS; t++) begin
            prod_in[ch][t] = $signed(coefs[t]) * $signed({1'b0, window[t][8*ch +: 8]});
         end
      end
   end

   assign valid3_in = s3_en ? win_valid : valid3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en && win_valid) begin
         prod_ff <= prod_in;
         pos3_ff <= win_pos;
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         acc[ch] = '0;
         for (int t = 0; t < cv3_pkg::TAPS; t++) begin
            acc[ch] = acc[ch] +
                      {{(cv3_pkg::ACC_W - cv3_pkg::PROD_W){prod_ff[ch][t][cv3_pkg::PROD_W-1]}},
                       prod_ff[ch][t]};
         end
         clamped[ch] = clamp_byte(acc[ch]);
      end
   end

   assign rsp_valid_in = out_en ? valid3_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && valid3_ff) begin
         red_ff     <= clamped[0];
         green_ff   <= color_mode ? clamped[1] : 8'd0;
         blue_ff    <= color_mode ? clamped[2] : 8'd0;
         pos_out_ff <= pos3_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = red_ff;
   assign rsp_out_green  = green_ff;
   assign rsp_out_blue   = blue_ff;
   assign rsp_center_row = pos_out_ff.row;
   assign rsp_center_col = pos_out_ff.col;

endmodule

### rtl/conv3x3_rgb_filter.sv
// 3x3 convolution filter, top level: control registers, pixel intake and kernel.
// Depends on cv3_pkg, cv3_line_window and cv3_kernel.
// The pixel completing a window passes stage-one, window, product and result registers.
// Throughput: one pixel per clock if unstalled, set by one read and write port per store.
// Reset clears counters, pipeline valids and registers (box blur, RGB, width 1024);
// line store contents stay undefined until written.
module conv3x3_rgb_filter (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_in_red,
   input  logic [7:0]   req_in_green,
   input  logic [7:0]   req_in_blue,
   input  logic         req_frame_start,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_red,
   output logic [7:0]   rsp_out_green,
   output logic [7:0]   rsp_out_blue,
   output logic [11:0]  rsp_center_row,
   output logic [9:0]   rsp_center_col,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [47:0]  csr_wdata
);

   logic [cv3_pkg::LINE_W-1:0] line_width_ff, line_width_in;
   logic                       color_mode_ff, color_mode_in;
   logic [47:0]                coef_ff [3];
   logic [47:0]                coef_in [3];
   cv3_pkg::kernel_type        coefs;
   logic                       down_ready;
   logic                       win_valid;
   cv3_pkg::window_type        window;
   cv3_pkg::pos_type           win_pos;

   always_comb begin
      line_width_in = line_width_ff;
      color_mode_in = color_mode_ff;
      coef_in       = coef_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cv3_pkg::CSR_LINE_WIDTH:  line_width_in = csr_wdata[cv3_pkg::LINE_W-1:0];
            cv3_pkg::CSR_COLOR_MODE:  color_mode_in = csr_wdata[0];
            cv3_pkg::CSR_COEF_TOP:    coef_in[0]    = csr_wdata;
            cv3_pkg::CSR_COEF_MID:    coef_in[1]    = csr_wdata;
            cv3_pkg::CSR_COEF_BOTTOM: coef_in[2]    = csr_wdata;
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= cv3_pkg::LINE_RESET;
         color_mode_ff <= 1'b1;
         coef_ff[0]    <= cv3_pkg::COEF_ROW_RESET;
         coef_ff[1]    <= cv3_pkg::COEF_ROW_RESET;
         coef_ff[2]    <= cv3_pkg::COEF_ROW_RESET;
      end else begin
         line_width_ff <= line_width_in;
         color_mode_ff <= color_mode_in;
         coef_ff       <= coef_in;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            coefs[r*3 + c] = coef_ff[r][16*c +: 16];
         end
      end
   end

   cv3_line_window u_line_window (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_red      (req_in_red),
      .req_in_green    (req_in_green),
      .req_in_blue     (req_in_blue),
      .req_frame_start (req_frame_start),
      .line_width      (line_width_ff),
      .down_ready      (down_ready),
      .win_valid       (win_valid),
      .window          (window),
      .win_pos         (win_pos)
   );

   cv3_kernel u_kernel (
      .clock          (clock),
      .reset          (reset),
      .win_valid      (win_valid),
      .window         (window),
      .win_pos        (win_pos),
      .coefs          (coefs),
      .color_mode     (color_mode_ff),
      .ready          (down_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_center_row (rsp_center_row),
      .rsp_center_col (rsp_center_col)
   );

endmodule

### test/tb_conv3x3_rgb_filter.sv
// Testbench for conv3x3_rgb_filter: streams pixel beats with random gaps and output stalls,
// predicts filtered pixels by model or directed table and checks each result beat in order.
// Depends on cv3_pkg and the conv3x3_rgb_filter RTL.
module tb_conv3x3_rgb_filter;

   localparam logic [2:0] CSR_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] CSR_LAST_UNUSED  = 3'd7;
   localparam int ROW_WRAP = 1 << cv3_pkg::ROW_W;
   localparam int RANDOM_ITEMS = 340;

   typedef enum int {
      K_BOX, K_IDENTITY, K_SHARPEN, K_SMALL, K_WIDE, K_MAX, K_MIN
   } kernel_kind_type;

   typedef struct packed {
      logic [7:0]                red;
      logic [7:0]                green;
      logic [7:0]                blue;
      logic [cv3_pkg::ROW_W-1:0] row;
      logic [cv3_pkg::COL_W-1:0] col;
   } filtered_px_type;

   typedef struct packed {
      logic [7:0]      red;
      logic [7:0]      green;
      logic [7:0]      blue;
      logic            frame_start;
      logic            typed;
      filtered_px_type px;
   } directed_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_red = 8'd0;
   logic [7:0]  req_in_green = 8'd0;
   logic [7:0]  req_in_blue = 8'd0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic [11:0] rsp_center_row;
   logic [9:0]  rsp_center_col;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = cv3_pkg::CSR_LINE_WIDTH;
   logic [47:0] csr_wdata = 48'd0;

   // local copy of the filter state and its registers
   logic [cv3_pkg::LINE_W-1:0] cfg_width = cv3_pkg::LINE_RESET;
   logic                       cfg_color = 1'b1;
   logic [47:0]                cfg_coef [3] = '{cv3_pkg::COEF_ROW_RESET,
                                                cv3_pkg::COEF_ROW_RESET,
                                                cv3_pkg::COEF_ROW_RESET};
   logic [cv3_pkg::PIX_W-1:0]  line_upper [cv3_pkg::MAX_WIDTH];
   logic [cv3_pkg::PIX_W-1:0]  line_lower [cv3_pkg::MAX_WIDTH];
   logic [cv3_pkg::PIX_W-1:0]  win [3][3] = '{default: '0};
   int unsigned                col_count = 0;
   int unsigned                row_count = 0;

   filtered_px_type pending_px[$];
   int              mismatches = 0;
   int              random_sent = 0;
   int unsigned     cycle_no = 0;
   int              stall_left = 0;
   bit              sending = 1'b0;

   // frame after reset at width 3: a flat frame, a frame start in mid-row, a second flat frame
   directed_row_type directed_rows [24] = '{
      '{8'd255, 8'd0,   8'd128, 1'b1, 1'b0, '0},
      '{8'd255, 8'd0,   8'd128, 1'b0, 1'b0, '0},
      '{8'd255, 8'd0,   8'd128, 1'b0, 1'b0, '0},
      '{8'd255, 8'd0,   8'd128, 1'b0, 1'b0, '0},
      '{8'd255, 8'd0,   8'd128, 1'b0, 1'b0, '0},
      '{8'd255, 8'd0,   8'd128, 1'b0, 1'b0, '0},
      '{8'd255, 8'd0,   8'd128, 1'b0, 1'b0, '0},
      '{8'd255, 8'd0,   8'd128, 1'b0, 1'b0, '0},
      '{8'd255, 8'd0,   8'd128, 1'b0, 1'b1, '{8'd251, 8'd0, 8'd126, 12'd1, 10'd1}},
      '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, '0},
      '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b1, 1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b0, 1'b1, '{8'd0, 8'd251, 8'd0, 12'd1, 10'd1}},
      '{8'd17,  8'd200, 8'd3,   1'b0, 1'b0, '0},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, '0},
      '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, '0},
      '{8'd128, 8'd64,  8'd1,   1'b0, 1'b0, '0}
   };

   conv3x3_rgb_filter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_red      (req_in_red),
      .req_in_green    (req_in_green),
      .req_in_blue     (req_in_blue),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_center_row  (rsp_center_row),
      .rsp_center_col  (rsp_center_col),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones, and idle-free stretches every so often
   function automatic int pick_gap();
      int roll;
      if (((cycle_no / 256) % 5) == 0) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return 8'd0;
      if (roll < 20) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [47:0] coef_row(input kernel_kind_type kind, input int row);
      logic [47:0] v;
      int k;
      case (kind)
         K_BOX:      v = cv3_pkg::COEF_ROW_RESET;
         K_IDENTITY: v = (row == 1) ? 48'h0000_0100_0000 : 48'h0;
         K_SHARPEN:  v = (row == 1) ? 48'hFF00_0500_FF00 : 48'h0000_FF00_0000;
         K_SMALL: begin
            for (k = 0; k < 3; k++)
               v[cv3_pkg::COEF_W*k +: cv3_pkg::COEF_W] = 16'($urandom_range(1024)) - 16'd512;
         end
         K_WIDE:     v = {16'($urandom), 32'($urandom)};
         K_MAX:      v = {3{16'h7FFF}};
         default:    v = {3{16'h8000}};
      endcase
      return v;
   endfunction

   // weighted 3x3 sum of one byte lane, clamped to 0..255
   function automatic logic [7:0] weigh_channel(input int lsb);
      longint acc;
      logic signed [cv3_pkg::COEF_W-1:0] w;
      int r, c;
      acc = 0;
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 3; c++) begin
            w = cfg_coef[r][cv3_pkg::COEF_W*c +: cv3_pkg::COEF_W];
            acc += longint'(w) * longint'(win[r][c][lsb +: 8]);
         end
      end
      if (acc < 0) return 8'd0;
      acc = acc >>> cv3_pkg::COEF_FRAC_BITS;
      return (acc > 255) ? 8'd255 : acc[7:0];
   endfunction

   // advance the window by one pixel; returns 1 when an interior centre completes
   function automatic bit filter_pixel(input logic [7:0] red, green, blue,
                                       input logic frame_start, output filtered_px_type px);
      int unsigned width, col;
      int r;
      bit hit;
      width = cfg_width;
      if (width < 3) width = 3;
      if (width > cv3_pkg::MAX_WIDTH) width = cv3_pkg::MAX_WIDTH;
      px = '0;
      if (frame_start) begin
         col_count = 0;
         row_count = 0;
      end
      col = col_count % cv3_pkg::MAX_WIDTH;
      for (r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = line_upper[col];
      win[1][2] = line_lower[col];
      win[2][2] = {blue, green, red};
      line_upper[col] = line_lower[col];
      line_lower[col] = {blue, green, red};
      hit = (row_count >= 2) && (col >= 2);
      if (hit) begin
         px.red   = weigh_channel(0);
         px.green = cfg_color ? weigh_channel(8) : 8'd0;
         px.blue  = cfg_color ? weigh_channel(16) : 8'd0;
         px.row   = cv3_pkg::ROW_W'(row_count - 1);
         px.col   = cv3_pkg::COL_W'(col - 1);
      end
      // a column at or past the last one ends the row, even after a width change
      if (col + 1 >= width) begin
         col_count = 0;
         row_count = (row_count + 1) % ROW_WRAP;
      end else begin
         col_count = col + 1;
      end
      return hit;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         cv3_pkg::CSR_LINE_WIDTH:  cfg_width = data[cv3_pkg::LINE_W-1:0];
         cv3_pkg::CSR_COLOR_MODE:  cfg_color = data[0];
         cv3_pkg::CSR_COEF_TOP:    cfg_coef[0] = data;
         cv3_pkg::CSR_COEF_MID:    cfg_coef[1] = data;
         cv3_pkg::CSR_COEF_BOTTOM: cfg_coef[2] = data;
         default: ;
      endcase
   endtask

   // program every register, plus one write to an unmapped index that must be dropped
   task automatic configure(input int width, input logic mode, input kernel_kind_type kind);
      write_reg(cv3_pkg::CSR_LINE_WIDTH, 48'(width));
      write_reg(cv3_pkg::CSR_COLOR_MODE, 48'(mode));
      write_reg(cv3_pkg::CSR_COEF_TOP, coef_row(kind, 0));
      write_reg(cv3_pkg::CSR_COEF_MID, coef_row(kind, 1));
      write_reg(cv3_pkg::CSR_COEF_BOTTOM, coef_row(kind, 2));
      write_reg(3'($urandom_range(CSR_LAST_UNUSED, CSR_FIRST_UNUSED)),
                {16'($urandom), 32'($urandom)});
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_pixel(input logic [7:0] red, green, blue, input logic frame_start,
                             input logic typed, input filtered_px_type typed_px);
      filtered_px_type px;
      int gap;
      req_valid       <= 1'b1;
      req_in_red      <= red;
      req_in_green    <= green;
      req_in_blue     <= blue;
      req_frame_start <= frame_start;
      sending = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (filter_pixel(red, green, blue, frame_start, px))
         pending_px.push_back(typed ? typed_px : px);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         sending = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_run(input int count, input logic open_frame, input int noise_pct);
      int i;
      logic fs;
      for (i = 0; i < count; i++) begin
         fs = (i == 0 && open_frame) || ($urandom_range(99) < noise_pct);
         push_pixel(pick_byte(), pick_byte(), pick_byte(), fs, 1'b0, '0);
      end
   endtask

   // hold off the sender until every filtered pixel is out, then let the pipeline empty
   task automatic settle();
      if (sending) begin
         req_valid <= 1'b0;
         sending = 1'b0;
      end
      while (pending_px.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_phase();
      int roll, width, eff, rows, count, noise;
      roll = $urandom_range(99);
      if (roll < 10) width = $urandom_range(2);
      else if (roll < 18) width = $urandom_range(64, 17);
      else width = $urandom_range(16, 3);
      eff   = (width < 3) ? 3 : width;
      rows  = (width > 16) ? $urandom_range(4, 3) : $urandom_range(8, 3);
      count = rows * eff + $urandom_range(eff - 1);
      noise = ($urandom_range(3) == 0) ? 15 : 2;
      configure(width, 1'($urandom_range(1)), kernel_kind_type'($urandom_range(K_MIN)));
      send_run(count, 1'b1, noise);
      random_sent += count;
      settle();
   endtask

   task automatic note_mismatch(input string what, input filtered_px_type want,
                                input filtered_px_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch (%s): expected r=%0d g=%0d b=%0d row=%0d col=%0d, %s",
                  what, want.red, want.green, want.blue, want.row, want.col,
                  $sformatf("got r=%0d g=%0d b=%0d row=%0d col=%0d",
                            got.red, got.green, got.blue, got.row, got.col));
   endtask

   always @(posedge clock) begin : check_results
      filtered_px_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_center_row, rsp_center_col};
         if (pending_px.size() == 0) begin
            note_mismatch("no result pending", '0, got);
         end else begin
            want = pending_px.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.row !== want.row || got.col !== want.col)
               note_mismatch("field differs", want, got);
         end
      end
   end

   always @(posedge clock) begin : drive_rsp_stall
      int gap;
      cycle_no <= cycle_no + 1;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         gap = pick_gap();
         rsp_stall  <= (gap != 0);
         stall_left <= (gap > 1) ? gap - 1 : 0;
      end
   end

   initial begin
      int i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      configure(3, 1'b1, K_BOX);
      for (i = 0; i < $size(directed_rows); i++)
         push_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                    directed_rows[i].frame_start, directed_rows[i].typed, directed_rows[i].px);
      settle();

      // width above the line store size acts as the full width: the first row never ends
      configure((1 << cv3_pkg::LINE_W) - 1, 1'b0, K_SHARPEN);
      send_run(40, 1'b1, 0);
      settle();

      // stop mid-row, then shrink the width so the current column ends the row
      configure(12, 1'b1, K_WIDE);
      send_run(5 * 12 + 7, 1'b1, 0);
      settle();
      configure(5, 1'b1, K_WIDE);
      send_run(4 * 5, 1'b0, 0);
      settle();

      while (random_sent < RANDOM_ITEMS) random_phase();

      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

### conv3x3_rgb_filter.f
rtl/cv3_pkg.sv
rtl/cv3_ram.sv
rtl/cv3_line_window.sv
rtl/cv3_kernel.sv
rtl/conv3x3_rgb_filter.sv
test/tb_conv3x3_rgb_filter.sv
